// ===== rtl/ctt_pkg.sv =====
// Shared types, codes and constants of the configuration text tokenizer.
// Used by the step logic, the result buffer and the top level; no dependencies.
`default_nettype none

package ctt_pkg;

    localparam int LINE_BITS_DEF = 32;
    localparam int LEN_W         = 22;
    localparam int NUM_W         = 31;
    localparam int LINE_OUT_W    = 32;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 22'h200000;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Configuration register indexes
    localparam logic CFG_COMMENT_IS_TOKEN = 1'b0;
    localparam logic CFG_MAX_TOKEN_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_CHAR    = 3'd1,
        KIND_STRING  = 3'd2,
        KIND_NUMBER  = 3'd3,
        KIND_COMMENT = 3'd4,
        KIND_EOF     = 3'd5,
        KIND_OVERRUN = 3'd6
    } t_kind;

    typedef enum logic [4:0] {
        MODE_SKIP    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_QUOTED  = 5'b00100,
        MODE_RUN     = 5'b01000,
        MODE_DONE    = 5'b10000
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [LEN_W-1:0]  plen;
        logic [NUM_W-1:0]  acc;
        logic              nvalid;
        logic              is_num;
    } t_state;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            byte_value;
        logic [NUM_W-1:0]      number_value;
        logic [LINE_OUT_W-1:0] line_number;
        logic [LEN_W-1:0]      token_length;
        logic                  last_of_run;
    } t_result;

    // Up to two results produced by one byte, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_res_pair;

    function automatic t_result mk_res(
        input t_kind                 kind,
        input logic [7:0]            bval,
        input logic [NUM_W-1:0]      num,
        input logic [LINE_OUT_W-1:0] line,
        input logic [LEN_W-1:0]      len
    );
        t_result r;
        r.kind         = kind;
        r.byte_value   = bval;
        r.number_value = num;
        r.line_number  = line;
        r.token_length = len;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctt_if.sv =====
// Channel interfaces of the tokenizer: text bytes in, results out.
// Valid/ready handshake; depends on ctt_pkg for field widths.
`default_nettype none

interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ctt_out_if
    import ctt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [2:0]            kind;
    logic [7:0]            byte_value;
    logic [NUM_W-1:0]      number_value;
    logic [LINE_OUT_W-1:0] line_number;
    logic [LEN_W-1:0]      token_length;
    logic                  last_of_run;

    modport source (output valid, output kind, output byte_value, output number_value,
                    output line_number, output token_length, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input byte_value, input number_value,
                    input line_number, input token_length, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ctt_scan.sv =====
// Byte classifier of the tokenizer: sorts one text byte into the classes that
// the step logic tests. Depends on ctt_pkg.
`default_nettype none

module ctt_scan
    import ctt_pkg::*;
(
    input  logic [7:0] i_byte,
    output logic       o_nl,
    output logic       o_sp,
    output logic       o_hash,
    output logic       o_quote,
    output logic       o_dig,
    output logic       o_alnum
);

    assign o_nl    = (i_byte == CH_NL);
    assign o_sp    = is_space(i_byte);
    assign o_hash  = (i_byte == CH_HASH);
    assign o_quote = (i_byte == CH_QUOTE);
    assign o_dig   = is_digit(i_byte);
    assign o_alnum = is_alnum(i_byte);

endmodule

`default_nettype wire

// ===== rtl/ctt_step.sv =====
// Combinational step logic of the tokenizer: scanner state and one byte in,
// next state and up to two results out. Depends on ctt_pkg and ctt_scan.
`default_nettype none

module ctt_step
    import ctt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  t_state                 i_st,
    input  logic [LINE_BITS-1:0]   i_line,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic                   i_cmt,
    input  logic [LEN_W-1:0]       i_max,
    output t_state                 o_st,
    output logic [LINE_BITS-1:0]   o_line,
    output t_res_pair              o_pair
);

    logic                 c_nl, c_sp, c_hash, c_quote, c_dig, c_alnum;
    logic                 ovf, max_zero;
    logic [LINE_BITS-1:0] line_inc;
    logic [34:0]          prod;
    t_result              run_end;
    t_state               st;
    logic [LINE_BITS-1:0] ln;
    logic                 has0, has1, do_skip, sk_has;
    t_result              res0, res1, sk_res;

    ctt_scan u_scan (
        .i_byte  (i_byte),
        .o_nl    (c_nl),
        .o_sp    (c_sp),
        .o_hash  (c_hash),
        .o_quote (c_quote),
        .o_dig   (c_dig),
        .o_alnum (c_alnum)
    );

    assign ovf      = (i_st.plen >= i_max);
    assign max_zero = (i_max == '0);
    assign line_inc = (i_line == '1) ? i_line : i_line + LINE_BITS'(1);

    // acc * 10 + digit, with room to see overflow past the 31-bit range
    assign prod = {1'b0, i_st.acc, 3'b000} + {3'b000, i_st.acc, 1'b0}
                + {31'd0, i_byte[3:0]};

    assign run_end = i_st.is_num
        ? mk_res(KIND_NUMBER, 8'd0, i_st.nvalid ? i_st.acc : '0,
                 LINE_OUT_W'(i_line), i_st.plen)
        : mk_res(KIND_STRING, 8'd0, '0, LINE_OUT_W'(i_line), i_st.plen);

    always_comb begin
        st      = i_st;
        ln      = i_line;
        has0    = 1'b0;
        has1    = 1'b0;
        res0    = '0;
        res1    = '0;
        do_skip = 1'b0;
        sk_has  = 1'b0;
        sk_res  = '0;

        if (i_st.mode == MODE_DONE) begin
            has0 = 1'b1;
            res0 = mk_res(KIND_EOF, 8'd0, '0, LINE_OUT_W'(ln), '0);
        end else if (i_last) begin
            if (i_st.mode == MODE_RUN) begin
                has0 = 1'b1;
                res0 = run_end;
            end else if (i_st.mode == MODE_QUOTED) begin
                has0 = 1'b1;
                res0 = mk_res(KIND_STRING, 8'd0, '0, LINE_OUT_W'(ln), i_st.plen);
            end
            if (has0) begin
                has1 = 1'b1;
                res1 = mk_res(KIND_EOF, 8'd0, '0, LINE_OUT_W'(ln), '0);
            end else begin
                has0 = 1'b1;
                res0 = mk_res(KIND_EOF, 8'd0, '0, LINE_OUT_W'(ln), '0);
            end
            st.mode = MODE_DONE;
            st.plen = '0;
        end else begin
            unique case (i_st.mode)
                MODE_COMMENT: begin
                    if (c_nl) begin
                        ln = line_inc;
                        if (i_cmt) begin
                            has0 = 1'b1;
                            res0 = mk_res(KIND_COMMENT, 8'd0, '0, LINE_OUT_W'(ln),
                                          i_st.plen);
                        end
                        st.mode = MODE_SKIP;
                        st.plen = '0;
                    end else if (i_cmt) begin
                        has0 = 1'b1;
                        if (ovf) begin
                            res0    = mk_res(KIND_OVERRUN, 8'd0, '0, LINE_OUT_W'(ln), '0);
                            st.mode = MODE_SKIP;
                            st.plen = '0;
                        end else begin
                            res0    = mk_res(KIND_PAYLOAD, i_byte, '0, LINE_OUT_W'(ln), '0);
                            st.plen = i_st.plen + LEN_W'(1);
                        end
                    end
                end
                MODE_QUOTED: begin
                    has0 = 1'b1;
                    if (c_quote) begin
                        res0    = mk_res(KIND_STRING, 8'd0, '0, LINE_OUT_W'(ln), i_st.plen);
                        st.mode = MODE_SKIP;
                        st.plen = '0;
                    end else if (ovf) begin
                        // the dropped byte is not counted, even a newline
                        res0    = mk_res(KIND_OVERRUN, 8'd0, '0, LINE_OUT_W'(ln), '0);
                        st.mode = MODE_SKIP;
                        st.plen = '0;
                    end else begin
                        res0    = mk_res(KIND_PAYLOAD, i_byte, '0, LINE_OUT_W'(ln), '0);
                        st.plen = i_st.plen + LEN_W'(1);
                        if (c_nl) begin
                            ln = line_inc;
                        end
                    end
                end
                MODE_RUN: begin
                    has0 = 1'b1;
                    if (c_alnum) begin
                        if (ovf) begin
                            res0    = mk_res(KIND_OVERRUN, 8'd0, '0, LINE_OUT_W'(ln), '0);
                            st.mode = MODE_SKIP;
                            st.plen = '0;
                        end else begin
                            res0    = mk_res(KIND_PAYLOAD, i_byte, '0, LINE_OUT_W'(ln), '0);
                            st.plen = i_st.plen + LEN_W'(1);
                            if (i_st.is_num && i_st.nvalid) begin
                                if (!c_dig || (|prod[34:31])) begin
                                    st.nvalid = 1'b0;
                                    st.acc    = '0;
                                end else begin
                                    st.acc = prod[30:0];
                                end
                            end
                        end
                    end else begin
                        // The run ends here and this byte is scanned afresh
                        res0    = run_end;
                        st.mode = MODE_SKIP;
                        st.plen = '0;
                        do_skip = 1'b1;
                    end
                end
                MODE_SKIP: begin
                    do_skip = 1'b1;
                end
                default: begin
                    do_skip = 1'b1;
                end
            endcase
        end

        // Payload length is always zero here, so overrun only when the limit is zero
        if (do_skip) begin
            if (c_nl) begin
                ln = line_inc;
            end else if (c_sp) begin
                sk_has = 1'b0;
            end else if (c_hash) begin
                st.mode = MODE_COMMENT;
                st.plen = '0;
                if (i_cmt) begin
                    sk_has = 1'b1;
                    if (max_zero) begin
                        sk_res  = mk_res(KIND_OVERRUN, 8'd0, '0, LINE_OUT_W'(ln), '0);
                        st.mode = MODE_SKIP;
                    end else begin
                        sk_res  = mk_res(KIND_PAYLOAD, i_byte, '0, LINE_OUT_W'(ln), '0);
                        st.plen = LEN_W'(1);
                    end
                end
            end else if (c_quote) begin
                st.mode = MODE_QUOTED;
                st.plen = '0;
            end else if (c_alnum) begin
                st.mode   = MODE_RUN;
                st.plen   = '0;
                st.is_num = c_dig;
                st.nvalid = 1'b1;
                st.acc    = '0;
                sk_has    = 1'b1;
                if (max_zero) begin
                    sk_res  = mk_res(KIND_OVERRUN, 8'd0, '0, LINE_OUT_W'(ln), '0);
                    st.mode = MODE_SKIP;
                end else begin
                    sk_res  = mk_res(KIND_PAYLOAD, i_byte, '0, LINE_OUT_W'(ln), '0);
                    st.plen = LEN_W'(1);
                    if (c_dig) begin
                        st.acc = {27'd0, i_byte[3:0]};
                    end
                end
            end else begin
                sk_has = 1'b1;
                sk_res = mk_res(KIND_CHAR, i_byte, '0, LINE_OUT_W'(ln), '0);
            end
            if (sk_has) begin
                if (has0) begin
                    has1 = 1'b1;
                    res1 = sk_res;
                end else begin
                    has0 = 1'b1;
                    res0 = sk_res;
                end
            end
        end

        if (has1) begin
            res1.last_of_run = 1'b1;
        end else if (has0) begin
            res0.last_of_run = 1'b1;
        end
    end

    assign o_st       = st;
    assign o_line     = ln;
    assign o_pair.cnt = {1'b0, has0} + {1'b0, has1};
    assign o_pair.r0  = res0;
    assign o_pair.r1  = res1;

endmodule

`default_nettype wire

// ===== rtl/ctt_obuf.sv =====
// Two-entry result buffer of the tokenizer: takes both results of one byte
// at once and hands them to the output channel beat by beat. Depends on ctt_pkg.
`default_nettype none

module ctt_obuf
    import ctt_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  logic              i_push,
    input  t_res_pair         i_pair,
    output logic              o_space,
    ctt_out_if.source         o_out
);

    logic [1:0] r_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       pop;
    logic       load;

    assign pop     = (r_cnt != 2'd0) && o_out.ready;
    assign load    = i_push && (i_pair.cnt != 2'd0);
    // A new pair fits only if the buffer is empty by the end of this cycle
    assign o_space = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= i_pair.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot0 <= i_pair.r0;
            r_slot1 <= i_pair.r1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.kind         = r_slot0.kind;
    assign o_out.byte_value   = r_slot0.byte_value;
    assign o_out.number_value = r_slot0.number_value;
    assign o_out.line_number  = r_slot0.line_number;
    assign o_out.token_length = r_slot0.token_length;
    assign o_out.last_of_run  = r_slot0.last_of_run;

    a_load_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> o_space)
        else $error("result pair loaded while the buffer still holds results");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !o_out.ready |=> (r_cnt == 2'd2) && $stable(r_slot0))
        else $error("full result buffer changed without a beat leaving");

endmodule

`default_nettype wire

// ===== rtl/config_text_tokenizer_top.sv =====
// Configuration text tokenizer: byte-stream lexer for configuration files.
//
// Input channel i_in carries one text byte per beat (data_byte, last_byte);
// a beat with last_byte set only ends the input. Output channel o_out carries
// result beats: kind, byte_value, number_value, line_number, token_length and
// last_of_run, which marks the final result caused by one input byte. A byte
// gives zero, one or two results. Configuration is written through
// i_cfg_we/i_cfg_idx/i_cfg_data (index 0 comment_is_token, 1 max_token_length)
// while no work is in flight.
//
// Each accepted byte is held in the input register, scanned there by the
// combinational step logic, and its results are registered into the output
// buffer, which presents them. A byte is taken every cycle as long as each
// byte gives at most one result and the receiver takes each result; a byte
// with two results holds the next one while the second beat drains, so the
// rate is one byte per cycle, or per result beat where there are more.
// When the receiver stalls, results wait in the two-entry buffer and the
// input register fills, after which i_in.ready falls. Reset clears the
// scanner to whitespace skipping at line 1 and restores the register defaults.
`default_nettype none

module config_text_tokenizer_top
    import ctt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [LEN_W-1:0]  i_cfg_data,
    ctt_in_if.sink            i_in,
    ctt_out_if.source         o_out
);

    logic                 r_cmt;
    logic [LEN_W-1:0]     r_max;
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    t_state               r_st;
    logic [LINE_BITS-1:0] r_line;

    t_state               n_st;
    logic [LINE_BITS-1:0] n_line;
    t_res_pair            pair;
    logic                 space;
    logic                 proc;
    logic                 in_acc;

    assign proc       = r_in_valid && ((pair.cnt == 2'd0) || space);
    assign i_in.ready = !r_in_valid || proc;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmt <= 1'b0;
            r_max <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COMMENT_IS_TOKEN: r_cmt <= i_cfg_data[0];
                CFG_MAX_TOKEN_LENGTH: r_max <= i_cfg_data;
                default:              r_cmt <= r_cmt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode   <= MODE_SKIP;
            r_st.plen   <= '0;
            r_st.acc    <= '0;
            r_st.nvalid <= 1'b1;
            r_st.is_num <= 1'b0;
            r_line      <= LINE_BITS'(1);
        end else if (proc) begin
            r_st   <= n_st;
            r_line <= n_line;
        end
    end

    ctt_step #(
        .LINE_BITS (LINE_BITS)
    ) u_step (
        .i_st   (r_st),
        .i_line (r_line),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .i_cmt  (r_cmt),
        .i_max  (r_max),
        .o_st   (n_st),
        .o_line (n_line),
        .o_pair (pair)
    );

    ctt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (proc),
        .i_pair  (pair),
        .o_space (space),
        .o_out   (o_out)
    );

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == MODE_DONE) |=> (r_st.mode == MODE_DONE))
        else $error("scanner left the end-of-input state without reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.nvalid |-> (r_st.acc == '0))
        else $error("invalidated number still holds a value");

    a_line_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_line >= $past(r_line)))
        else $error("line count went backwards");

    a_done_no_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == MODE_DONE) || (r_st.mode == MODE_SKIP) |-> (r_st.plen == '0))
        else $error("payload length left over outside a token");

endmodule

`default_nettype wire
